FILE: rtl/mpv_pkg.sv
// Package: fixed-point constants and helpers for the motor velocity loop.
package mpv_pkg;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int CFG_IDX_W = 3;
	localparam int MUL_DIGIT = 4;
	localparam int MUL_STEPS = 64 / MUL_DIGIT;

	localparam logic [CFG_IDX_W-1:0] REG_MODE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_DUTY_SCALE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_TIMER_TOP = 3'd7;

	localparam logic signed [31:0] LIM_99 = 32'sd99 <<< FRAC_BITS;
	localparam logic signed [31:0] LIM_90 = 32'sd90 <<< FRAC_BITS;
	localparam logic signed [31:0] DECAY_09 = 32'((9 * (1 << FRAC_BITS) + 5) / 10);

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) return 32'sh7fffffff;
		if (v < -66'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction
endpackage

FILE: rtl/mpv_mul.sv
// Digit-serial signed 32x32 multiplier, four bits of the multiplier per cycle.
module mpv_mul import mpv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic busy,
	output logic signed [63:0] product
);
	logic [63:0] mcand_q;
	logic [63:0] mplier_q;
	logic [63:0] acc_q;
	logic [$clog2(MUL_STEPS+1)-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= ($clog2(MUL_STEPS+1))'(MUL_STEPS);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// mod 2^64 product of sign-extended operands equals the signed product
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= 64'(signed'(a));
			mplier_q <= 64'(signed'(b));
			acc_q <= '0;
		end else if (cnt_q != '0) begin
			acc_q <= acc_q + mcand_q * 64'(mplier_q[MUL_DIGIT-1:0]);
			mcand_q <= mcand_q << MUL_DIGIT;
			mplier_q <= mplier_q >> MUL_DIGIT;
		end
	end

	assign busy = (cnt_q != '0);
	assign product = signed'(acc_q);
endmodule

FILE: rtl/motor_pi_velocity_pwm.sv
// Velocity PI loop with H-bridge PWM compare; one shared digit-serial multiplier.
// Set-point request: open mode loads the clamped drive level directly; closed mode does one multiply.
// Tick request: open mode two multiplies, closed mode five multiplies, or six when
// the integral decays; each multiply holds the FSM in ST_WAIT until the multiplier is done.
// One request in flight at a time; input is held off while a result waits on out_ready.
// Reset: drive, target, integral, speed, position zero, config registers at reset values, output idle.
module motor_pi_velocity_pwm import mpv_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic cmd,
	input  logic signed [31:0] set_value,
	input  logic [15:0] encoder_count,
	output logic out_valid,
	input  logic out_ready,
	output logic [14:0] compare_forward,
	output logic [14:0] compare_reverse,
	output logic signed [15:0] speed,
	output logic signed [31:0] position,
	output logic signed [31:0] drive_level
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_SETPT, ST_ENC, ST_ERR, ST_MP, ST_MI1, ST_MI2,
		ST_MDEC, ST_MV, ST_MD, ST_MT, ST_PWM, ST_OUT, ST_WAIT
	} state_t;

	logic mode_q;
	logic signed [1:0] dir_q;
	logic signed [31:0] gain_p_q, gain_i_q, vel_scale_q, duty_scale_q;
	logic [30:0] tick_period_q;
	logic [14:0] timer_top_q;

	logic signed [31:0] drive_q, target_q, integral_q, err_q, pterm_q, tmp_q;
	logic [15:0] prev_q;
	logic signed [15:0] speed_q;
	logic [31:0] travel_q;
	logic signed [31:0] set_q;
	logic [15:0] enc_q;
	state_t state_q, ret_q;
	logic [14:0] fwd_q, rev_q;
	logic out_valid_q;

	logic mul_start;
	logic signed [31:0] mul_a, mul_b;
	logic mul_busy;
	logic signed [63:0] mul_p;
	logic signed [31:0] qres;
	logic signed [65:0] fl;

	mpv_mul u_mul (.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.busy(mul_busy), .product(mul_p));

	// floor shift then saturate
	assign fl = 66'(mul_p >>> FRAC_BITS);
	assign qres = sat32(fl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			dir_q <= 2'sd1;
			gain_p_q <= '0;
			gain_i_q <= '0;
			tick_period_q <= 31'd65536;
			vel_scale_q <= 32'sd65536;
			duty_scale_q <= 32'sd655;
			timer_top_q <= 15'd999;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE: mode_q <= cfg_data[0];
				REG_DIRECTION: dir_q <= cfg_data[1:0];
				REG_GAIN_P: gain_p_q <= cfg_data;
				REG_GAIN_I: gain_i_q <= cfg_data;
				REG_TICK_PERIOD: tick_period_q <= cfg_data[30:0];
				REG_VEL_SCALE: vel_scale_q <= cfg_data;
				REG_DUTY_SCALE: duty_scale_q <= cfg_data;
				REG_TIMER_TOP: timer_top_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	logic [15:0] now_cnt;
	logic [15:0] delta;
	logic signed [31:0] sp_sat;
	logic signed [65:0] csc;
	logic signed [17:0] cmag;
	assign now_cnt = (dir_q == 2'sd1) ? enc_q : (dir_q == -2'sd1) ? (16'd0 - enc_q) :
		(dir_q == -2'sd2) ? (16'd0 - (enc_q << 1)) : 16'd0;
	assign delta = now_cnt - prev_q;
	assign sp_sat = sat32(66'(speed_q) <<< FRAC_BITS);
	// q*top / 2^F truncating toward zero
	assign csc = (mul_p < 0) ? -66'((-mul_p) >>> FRAC_BITS) : 66'(mul_p >>> FRAC_BITS);
	assign cmag = (csc > 66'sd32767) ? 18'sd32767 : (csc < -66'sd32768) ? 18'sd32768 :
		(csc < 0) ? 18'(-csc) : 18'(csc);

	// chained multiplies take the previous product straight from qres
	always_comb begin
		mul_start = 1'b0;
		mul_a = drive_q;
		mul_b = duty_scale_q;
		unique case (state_q)
			ST_SETPT: begin mul_start = 1'b1; mul_a = set_q; mul_b = vel_scale_q; end
			ST_MP: begin mul_start = !mul_busy; mul_a = gain_p_q; mul_b = err_q; end
			ST_MI1: begin mul_start = !mul_busy; mul_a = gain_i_q; mul_b = integral_q; end
			ST_MI2: begin
				mul_start = !mul_busy;
				mul_a = qres;
				mul_b = signed'({1'b0, tick_period_q});
			end
			ST_MDEC: begin mul_start = !mul_busy; mul_a = integral_q; mul_b = DECAY_09; end
			ST_MD: begin mul_start = !mul_busy; mul_a = drive_q; mul_b = duty_scale_q; end
			ST_MT: begin
				mul_start = !mul_busy;
				mul_a = qres;
				mul_b = signed'({17'd0, timer_top_q});
			end
			default: ;
		endcase
	end

	// each multiply state: issue (busy low), then wait in ST_WAIT, returning to ret_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			drive_q <= '0; target_q <= '0; integral_q <= '0;
			prev_q <= '0; speed_q <= '0; travel_q <= '0;
		end else begin
			if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					set_q <= set_value;
					enc_q <= encoder_count;
					if (!cmd) begin
						if (mode_q) state_q <= ST_SETPT;
						else begin
							drive_q <= (set_value > LIM_99) ? LIM_99 :
								(set_value < -LIM_99) ? -LIM_99 : set_value;
						end
					end else state_q <= ST_ENC;
				end
				ST_SETPT: begin state_q <= ST_WAIT; ret_q <= ST_IDLE; end
				ST_ENC: begin
					speed_q <= signed'(delta);
					prev_q <= now_cnt;
					travel_q <= travel_q + 32'(signed'(delta));
					state_q <= mode_q ? ST_ERR : ST_MD;
				end
				ST_ERR: begin
					err_q <= sat32(66'(target_q) - 66'(sp_sat));
					if (target_q == 0 || (target_q > 0 && drive_q < 0) ||
						(target_q < 0 && drive_q > 0)) integral_q <= '0;
					state_q <= ST_MP;
				end
				ST_MP: begin state_q <= ST_WAIT; ret_q <= ST_MI1; end
				ST_MI1: begin pterm_q <= qres; state_q <= ST_WAIT; ret_q <= ST_MI2; end
				ST_MI2: begin tmp_q <= qres; state_q <= ST_WAIT; ret_q <= ST_MV; end
				ST_MV: begin
					tmp_q <= sat32(66'(pterm_q) + 66'(qres));
					if (sat32(66'(pterm_q) + 66'(qres)) > LIM_90) state_q <= ST_MDEC;
					else begin
						integral_q <= sat32(66'(integral_q) + 66'(err_q));
						drive_q <= sat32(66'(pterm_q) + 66'(qres));
						state_q <= ST_MD;
					end
				end
				ST_MDEC: begin drive_q <= tmp_q; state_q <= ST_WAIT; ret_q <= ST_PWM; end
				ST_PWM: begin integral_q <= qres; state_q <= ST_MD; end
				ST_MD: begin state_q <= ST_WAIT; ret_q <= ST_MT; end
				ST_MT: begin tmp_q <= qres; state_q <= ST_WAIT; ret_q <= ST_OUT; end
				ST_OUT: if (!out_valid_q || out_ready) begin
					fwd_q <= '0; rev_q <= '0;
					if (csc < 0) rev_q <= (cmag > 18'(timer_top_q)) ? timer_top_q : cmag[14:0];
					else fwd_q <= (cmag > 18'(timer_top_q)) ? timer_top_q : cmag[14:0];
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_WAIT: if (!mul_busy && !mul_start) begin
					if (ret_q == ST_IDLE) target_q <= qres;
					state_q <= ret_q;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result fields come straight from state, so no new request until the result leaves
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign compare_forward = fwd_q;
	assign compare_reverse = rev_q;
	assign speed = speed_q;
	assign position = travel_q;
	assign drive_level = drive_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (compare_forward == '0 || compare_reverse == '0))
		else $error("both compare channels active");
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (compare_forward <= timer_top_q && compare_reverse <= timer_top_q))
		else $error("compare above timer top");
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT && !mul_busy) |-> !mul_start)
		else $error("multiplier restarted while waiting");
endmodule
